// File: rtl/c65pd_pkg.sv
// ----------------------------------------------------------------------------
// c65pd_pkg
// Shared types, addressing mode codes and opcode tables for the 65816
// instruction predecoder.
// ----------------------------------------------------------------------------
`default_nettype none

package c65pd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ACC_NARROW = 2'd0;
  localparam logic [1:0] CFG_IDX_NARROW = 2'd1;
  localparam logic [1:0] CFG_START_ADDR = 2'd2;

  localparam int unsigned CfgDataWidth = 16;

  // addressing modes
  localparam logic [4:0] MODE_NONE = 5'd0;
  localparam logic [4:0] MODE_ABS  = 5'd1;
  localparam logic [4:0] MODE_AIX  = 5'd2;
  localparam logic [4:0] MODE_ABX  = 5'd3;
  localparam logic [4:0] MODE_ABY  = 5'd4;
  localparam logic [4:0] MODE_ABI  = 5'd5;
  localparam logic [4:0] MODE_ALX  = 5'd6;
  localparam logic [4:0] MODE_ABL  = 5'd7;
  localparam logic [4:0] MODE_ACC  = 5'd8;
  localparam logic [4:0] MODE_BLK  = 5'd9;
  localparam logic [4:0] MODE_DIX  = 5'd10;
  localparam logic [4:0] MODE_DPX  = 5'd11;
  localparam logic [4:0] MODE_DPY  = 5'd12;
  localparam logic [4:0] MODE_DIY  = 5'd13;
  localparam logic [4:0] MODE_DLY  = 5'd14;
  localparam logic [4:0] MODE_DIL  = 5'd15;
  localparam logic [4:0] MODE_DI   = 5'd16;
  localparam logic [4:0] MODE_DP   = 5'd17;
  localparam logic [4:0] MODE_IMM  = 5'd18;
  localparam logic [4:0] MODE_IMP  = 5'd19;
  localparam logic [4:0] MODE_RLL  = 5'd20;
  localparam logic [4:0] MODE_REL  = 5'd21;
  localparam logic [4:0] MODE_STK  = 5'd22;
  localparam logic [4:0] MODE_SR   = 5'd23;
  localparam logic [4:0] MODE_SRY  = 5'd24;

  // special opcodes
  localparam logic [7:0] OPC_LDX_IMM = 8'hA2;
  localparam logic [7:0] OPC_PEA     = 8'hF4;
  localparam logic [3:0] LO_ACC_IMM  = 4'h9;
  localparam logic [3:0] LO_IDX_IMM  = 4'h0;

  localparam logic [4:0] MODE_TABLE [256] = '{
    MODE_STK,MODE_DIX,MODE_STK,MODE_SR, MODE_DP, MODE_DP, MODE_DP, MODE_DIL,
    MODE_STK,MODE_IMM,MODE_ACC,MODE_STK,MODE_ABS,MODE_ABS,MODE_ABS,MODE_ABL,
    MODE_REL,MODE_DIY,MODE_DI, MODE_SRY,MODE_DP, MODE_DPX,MODE_DPX,MODE_DLY,
    MODE_IMP,MODE_ABY,MODE_ACC,MODE_IMP,MODE_ABS,MODE_ABX,MODE_ABX,MODE_ALX,
    MODE_ABS,MODE_DIX,MODE_ABL,MODE_SR, MODE_DP, MODE_DP, MODE_DP, MODE_DIL,
    MODE_STK,MODE_IMM,MODE_ACC,MODE_STK,MODE_ABS,MODE_ABS,MODE_ABS,MODE_ABL,
    MODE_REL,MODE_DIY,MODE_DI, MODE_SRY,MODE_DPX,MODE_DPX,MODE_DPX,MODE_DLY,
    MODE_IMP,MODE_ABY,MODE_ACC,MODE_IMP,MODE_ABX,MODE_ABX,MODE_ABX,MODE_ALX,
    MODE_STK,MODE_DIX,MODE_IMM,MODE_SR, MODE_BLK,MODE_DP, MODE_DP, MODE_DIL,
    MODE_STK,MODE_IMM,MODE_ACC,MODE_STK,MODE_ABS,MODE_ABS,MODE_ABS,MODE_ABL,
    MODE_REL,MODE_DIY,MODE_DI, MODE_SRY,MODE_BLK,MODE_DPX,MODE_DPX,MODE_DLY,
    MODE_IMP,MODE_ABY,MODE_STK,MODE_IMP,MODE_ABL,MODE_ABX,MODE_ABX,MODE_ALX,
    MODE_STK,MODE_DIX,MODE_ABS,MODE_SR, MODE_DP, MODE_DP, MODE_DP, MODE_DIL,
    MODE_STK,MODE_IMM,MODE_ACC,MODE_STK,MODE_ABI,MODE_ABS,MODE_ABS,MODE_ABL,
    MODE_REL,MODE_DIY,MODE_DI, MODE_SRY,MODE_DPX,MODE_DPX,MODE_DPX,MODE_DLY,
    MODE_IMP,MODE_ABY,MODE_STK,MODE_IMP,MODE_AIX,MODE_ABX,MODE_ABX,MODE_ALX,
    MODE_REL,MODE_DIX,MODE_RLL,MODE_SR, MODE_DP, MODE_DP, MODE_DP, MODE_DIL,
    MODE_IMP,MODE_IMM,MODE_IMP,MODE_STK,MODE_ABS,MODE_ABS,MODE_ABS,MODE_ABL,
    MODE_REL,MODE_DIY,MODE_DI, MODE_SRY,MODE_DPX,MODE_DPX,MODE_DPY,MODE_DLY,
    MODE_IMP,MODE_ABY,MODE_IMP,MODE_IMP,MODE_ABS,MODE_ABX,MODE_ABX,MODE_ALX,
    MODE_IMM,MODE_DIX,MODE_IMM,MODE_SR, MODE_DP, MODE_DP, MODE_DP, MODE_DIL,
    MODE_IMP,MODE_IMM,MODE_IMP,MODE_STK,MODE_ABS,MODE_ABS,MODE_ABS,MODE_ABL,
    MODE_REL,MODE_DIY,MODE_DI, MODE_SRY,MODE_DPX,MODE_DPX,MODE_DPY,MODE_DLY,
    MODE_IMP,MODE_ABY,MODE_IMP,MODE_IMP,MODE_ABX,MODE_ABX,MODE_ABY,MODE_ALX,
    MODE_IMM,MODE_DIX,MODE_IMM,MODE_SR, MODE_DP, MODE_DP, MODE_DP, MODE_DIL,
    MODE_IMP,MODE_IMM,MODE_IMP,MODE_IMP,MODE_ABS,MODE_ABS,MODE_ABS,MODE_ABL,
    MODE_REL,MODE_DIY,MODE_DI, MODE_SRY,MODE_DP, MODE_DPX,MODE_DPX,MODE_DLY,
    MODE_IMP,MODE_ABY,MODE_STK,MODE_IMP,MODE_ABI,MODE_ABX,MODE_ABX,MODE_ALX,
    MODE_IMM,MODE_DIX,MODE_IMM,MODE_SR, MODE_DP, MODE_DP, MODE_DP, MODE_DIL,
    MODE_IMP,MODE_IMM,MODE_IMP,MODE_IMP,MODE_ABS,MODE_ABS,MODE_ABS,MODE_ABL,
    MODE_REL,MODE_DIY,MODE_DI, MODE_SRY,MODE_IMM,MODE_DPX,MODE_DPX,MODE_DLY,
    MODE_IMP,MODE_ABY,MODE_STK,MODE_IMP,MODE_AIX,MODE_ABX,MODE_ABX,MODE_ALX
  };

  // operand bytes implied by an addressing mode
  function automatic logic [1:0] mode_operand_len(logic [4:0] mode);
    logic [1:0] len;
    case (mode)
      MODE_ABS, MODE_AIX, MODE_ABX, MODE_ABY, MODE_ABI,
      MODE_BLK, MODE_RLL:                                  len = 2'd2;
      MODE_ALX, MODE_ABL:                                  len = 2'd3;
      MODE_DIX, MODE_DPX, MODE_DPY, MODE_DIY, MODE_DLY,
      MODE_DIL, MODE_DI, MODE_DP, MODE_IMM, MODE_REL,
      MODE_SR, MODE_SRY:                                   len = 2'd1;
      default:                                             len = 2'd0;
    endcase
    return len;
  endfunction

  typedef struct packed {
    logic [4:0] mode;
    logic [1:0] size;
  } dec_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [15:0] instruction_address;
    logic [7:0]  opcode;
    logic [4:0]  mode;
    logic [2:0]  length;
    logic [23:0] operand;
    logic [15:0] branch_target;
    logic        incomplete;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/c65pd_len_decode.sv
// ----------------------------------------------------------------------------
// c65pd_len_decode
// Opcode to addressing mode and operand byte count, with M/X immediates.
// ----------------------------------------------------------------------------
`default_nettype none

module c65pd_len_decode (
  input  wire logic [7:0]     opcode_i,
  input  wire logic           acc_narrow_i,
  input  wire logic           idx_narrow_i,
  output c65pd_pkg::dec_t     dec_o
);

  logic [4:0] mode;
  logic [1:0] size;

  always_comb begin
    mode = c65pd_pkg::MODE_TABLE[opcode_i];
    size = c65pd_pkg::mode_operand_len(mode);
    if (mode == c65pd_pkg::MODE_IMM) begin
      if (opcode_i[3:0] == c65pd_pkg::LO_ACC_IMM) begin
        size = acc_narrow_i ? 2'd1 : 2'd2;
      end
      if (opcode_i[3:0] == c65pd_pkg::LO_IDX_IMM || opcode_i == c65pd_pkg::OPC_LDX_IMM) begin
        size = idx_narrow_i ? 2'd1 : 2'd2;
      end
      // push effective address always carries a 16-bit operand
      if (opcode_i == c65pd_pkg::OPC_PEA) begin
        size = 2'd2;
      end
    end
  end

  assign dec_o.mode = mode;
  assign dec_o.size = size;

endmodule

`default_nettype wire

// File: rtl/c65pd_out_buf.sv
// ----------------------------------------------------------------------------
// c65pd_out_buf
// Two-entry result buffer that decouples the decoder from output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module c65pd_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire c65pd_pkg::out_t push_data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output c65pd_pkg::out_t      data_o
);

  c65pd_pkg::out_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cpu65816_instruction_predecoder.sv
// ----------------------------------------------------------------------------
// cpu65816_instruction_predecoder
// A result is pushed into the two-entry result buffer when the byte that
// ends its instruction (or the stream) is taken. Throughput: one code byte
// per cycle while the result buffer is not full, set by the combinational
// decode/gather step. Reset: asynchronous, active low; flags M=X=1, start
// address and all tracking state cleared, result buffer empty.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu65816_instruction_predecoder #(
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [c65pd_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire c65pd_pkg::in_t                      in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output c65pd_pkg::out_t                          out_data_o
);

  logic                    acc_narrow_q, idx_narrow_q;
  logic [15:0]             start_addr_q;
  logic [1:0]              rem_q, rem_d;
  logic [1:0]              cnt_q, cnt_d;
  logic [7:0]              opc_q, opc_d;
  logic [4:0]              mode_q, mode_d;
  logic [23:0]             opnd_q, opnd_d;
  logic [ADDRESS_BITS-1:0] iaddr_q, iaddr_d;
  logic [ADDRESS_BITS-1:0] naddr_q, naddr_d;

  c65pd_pkg::dec_t dec;
  c65pd_pkg::out_t res;
  logic            accept;
  logic            full;
  logic            emit;
  logic            partial;
  logic [1:0]      rem_new;
  logic [15:0]     target;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  c65pd_len_decode u_dec (
    .opcode_i     (in_data_i.code_byte),
    .acc_narrow_i (acc_narrow_q),
    .idx_narrow_i (idx_narrow_q),
    .dec_o        (dec)
  );

  always_comb begin
    iaddr_d = iaddr_q;
    opc_d   = opc_q;
    mode_d  = mode_q;
    opnd_d  = opnd_q;
    cnt_d   = cnt_q;
    rem_new = rem_q;
    if (rem_q == 2'd0) begin
      iaddr_d = naddr_q;
      opc_d   = in_data_i.code_byte;
      mode_d  = dec.mode;
      opnd_d  = '0;
      cnt_d   = 2'd0;
      rem_new = dec.size;
    end else begin
      // little-endian gather
      case (cnt_q)
        2'd0:    opnd_d = {opnd_q[23:8], in_data_i.code_byte};
        2'd1:    opnd_d = {opnd_q[23:16], in_data_i.code_byte, opnd_q[7:0]};
        default: opnd_d = {in_data_i.code_byte, opnd_q[15:0]};
      endcase
      cnt_d   = cnt_q + 2'd1;
      rem_new = rem_q - 2'd1;
    end

    partial = (rem_new != 2'd0);
    emit    = !partial || in_data_i.stream_end;

    target = 16'd0;
    if (!partial && mode_d == c65pd_pkg::MODE_REL) begin
      target = iaddr_d[15:0] + 16'd2 + {{8{opnd_d[7]}}, opnd_d[7:0]};
    end else if (!partial && mode_d == c65pd_pkg::MODE_RLL) begin
      target = iaddr_d[15:0] + 16'd3 + opnd_d[15:0];
    end

    res.instruction_address = iaddr_d[15:0];
    res.opcode              = opc_d;
    res.mode                = mode_d;
    res.length              = 3'd1 + {1'b0, cnt_d} + {1'b0, rem_new};
    res.operand             = opnd_d;
    res.branch_target       = target;
    res.incomplete          = partial;

    rem_d   = in_data_i.stream_end ? 2'd0 : rem_new;
    naddr_d = in_data_i.stream_end ? ADDRESS_BITS'(start_addr_q)
                                   : naddr_q + ADDRESS_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_narrow_q <= 1'b1;
      idx_narrow_q <= 1'b1;
      start_addr_q <= '0;
      rem_q        <= 2'd0;
      cnt_q        <= 2'd0;
      opc_q        <= '0;
      mode_q       <= c65pd_pkg::MODE_NONE;
      opnd_q       <= '0;
      iaddr_q      <= '0;
      naddr_q      <= '0;
    end else begin
      if (accept) begin
        rem_q   <= rem_d;
        cnt_q   <= cnt_d;
        opc_q   <= opc_d;
        mode_q  <= mode_d;
        opnd_q  <= opnd_d;
        iaddr_q <= iaddr_d;
      end
      // a start address write reloads the next fetch address
      if (cfg_we_i && cfg_index_i == c65pd_pkg::CFG_START_ADDR) begin
        naddr_q <= ADDRESS_BITS'(cfg_data_i);
      end else if (accept) begin
        naddr_q <= naddr_d;
      end
      // the user must write configuration only while idle; the block does not enforce this
      if (cfg_we_i) begin
        case (cfg_index_i)
          c65pd_pkg::CFG_ACC_NARROW: acc_narrow_q <= cfg_data_i[0];
          c65pd_pkg::CFG_IDX_NARROW: idx_narrow_q <= cfg_data_i[0];
          c65pd_pkg::CFG_START_ADDR: start_addr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  c65pd_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && emit),
    .push_data_i (res),
    .full_o      (full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/c65pd_checker.sv
// ----------------------------------------------------------------------------
// c65pd_checker
// Port-level checks on the predecoder result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module c65pd_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire c65pd_pkg::out_t out_data_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_partial_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.incomplete |-> out_data_o.branch_target == 16'd0)
    else $error("partial instruction carries a branch target");

  a_target_only_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode != c65pd_pkg::MODE_REL
      && out_data_o.mode != c65pd_pkg::MODE_RLL |-> out_data_o.branch_target == 16'd0)
    else $error("branch target on non-relative mode");

  a_length_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.length != 3'd0 && out_data_o.length <= 3'd4)
    else $error("instruction length out of range");

endmodule

bind cpu65816_instruction_predecoder c65pd_checker u_c65pd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
